@@ design/tli_pkg.sv @@
`timescale 1ns / 1ps
package tli_pkg;
    localparam int TableDepth = 256;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = $clog2(TableDepth + 1);

    typedef logic [AddrW-1:0] addr_t;
    typedef logic [CountW-1:0] count_t;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_LOW = 3'd1;
    localparam logic [2:0] ST_HIGH = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_VACUUM = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_SCAN = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_RD0 = 10'b0000001000,
        S_RD1 = 10'b0000010000,
        S_LAT1 = 10'b0000100000,
        S_MUL = 10'b0001000000,
        S_SUM = 10'b0010000000,
        S_DIV = 10'b0100000000,
        S_OUT = 10'b1000000000
    } state_t;
endpackage

@@ design/table_linear_interpolator.sv @@
`timescale 1ns / 1ps
// clear and append finish on accept; empty and vacuum queries answer in the cycle after accept
// a query scans one key per S_SCAN/S_CHECK pair; a clamped answer is ready right after the scan
// interpolation then reads the lower entry, multiplies, sums, divides bit-serially and loads the
// result; one word in flight at a time
// rst_n asynchronous active low: clears the entry count, vacuum mode and control state;
// table memories are not cleared
module table_linear_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] energy,
    input  logic [31:0] delta_value,
    input  logic [31:0] beta_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] delta_result,
    output logic [31:0] beta_result,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import tli_pkg::*;

    logic [31:0] key_mem [TableDepth];
    logic [31:0] dlt_mem [TableDepth];
    logic [31:0] bet_mem [TableDepth];

    state_t state_reg;
    count_t count_reg;
    logic vacuum_reg;
    logic [31:0] e_reg;
    count_t idx_reg;
    addr_t raddr;
    logic [31:0] key_q, dlt_q, bet_q;
    logic [31:0] k0_reg, d0_reg, b0_reg, k1_reg, d1_reg, b1_reg;
    logic [31:0] n_reg, dd_reg;
    logic [63:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [64:0] numd_reg, numb_reg, remd_reg, remb_reg;
    logic [6:0] bit_reg;
    logic out_valid_reg;
    logic [31:0] od_reg, ob_reg;
    logic [2:0] ost_reg;
    logic in_acc;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign delta_result = od_reg;
    assign beta_result = ob_reg;
    assign status = ost_reg;

    // memory read address
    always_comb
    begin
        raddr = idx_reg[AddrW-1:0];
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (in_acc && action == ACT_APPEND && count_reg < count_t'(TableDepth))
        begin
            key_mem[count_reg[AddrW-1:0]] <= energy;
            dlt_mem[count_reg[AddrW-1:0]] <= delta_value;
            bet_mem[count_reg[AddrW-1:0]] <= beta_value;
        end
        key_q <= key_mem[raddr];
        dlt_q <= dlt_mem[raddr];
        bet_q <= bet_mem[raddr];
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            vacuum_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                vacuum_reg <= cfg_data;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        e_reg <= energy;
                        idx_reg <= '0;
                        if (action == ACT_CLEAR)
                            count_reg <= '0;
                        else if (action == ACT_APPEND)
                        begin
                            if (count_reg < count_t'(TableDepth))
                                count_reg <= count_reg + 1'b1;
                        end
                        else if (action == ACT_QUERY)
                        begin
                            od_reg <= '0;
                            ob_reg <= '0;
                            if (vacuum_reg)
                            begin
                                ost_reg <= ST_VACUUM;
                                out_valid_reg <= 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                ost_reg <= ST_EMPTY;
                                out_valid_reg <= 1'b1;
                            end
                            else
                                state_reg <= S_SCAN;
                        end
                    end
                end
                // issue read of key at idx
                S_SCAN:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (e_reg < key_q)
                    begin
                        k1_reg <= key_q;
                        d1_reg <= dlt_q;
                        b1_reg <= bet_q;
                        if (idx_reg == '0)
                        begin
                            od_reg <= dlt_q;
                            ob_reg <= bet_q;
                            ost_reg <= ST_LOW;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                            state_reg <= S_RD0;
                        end
                    end
                    else if (idx_reg + 1'b1 == count_reg)
                    begin
                        od_reg <= dlt_q;
                        ob_reg <= bet_q;
                        ost_reg <= ST_HIGH;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_RD0:
                    state_reg <= S_RD1;
                S_RD1:
                begin
                    k0_reg <= key_q;
                    d0_reg <= dlt_q;
                    b0_reg <= bet_q;
                    state_reg <= S_LAT1;
                end
                S_LAT1:
                begin
                    n_reg <= e_reg - k0_reg;
                    dd_reg <= k1_reg - k0_reg;
                    state_reg <= S_MUL;
                end
                // four 32x32 products, registered
                S_MUL:
                begin
                    pa_reg <= 64'(d1_reg) * 64'(n_reg);
                    pb_reg <= 64'(d0_reg) * 64'(dd_reg - n_reg);
                    pc_reg <= 64'(b1_reg) * 64'(n_reg);
                    pd_reg <= 64'(b0_reg) * 64'(dd_reg - n_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    numd_reg <= 65'(pa_reg) + 65'(pb_reg) + 65'(dd_reg[31:1]);
                    numb_reg <= 65'(pc_reg) + 65'(pd_reg) + 65'(dd_reg[31:1]);
                    remd_reg <= '0;
                    remb_reg <= '0;
                    bit_reg <= 7'd65;
                    state_reg <= S_DIV;
                end
                // restoring divide, one quotient bit per cycle
                S_DIV:
                begin
                    begin
                        logic [65:0] td, tb;
                        td = {remd_reg, numd_reg[64]};
                        tb = {remb_reg, numb_reg[64]};
                        if (td >= 66'(dd_reg))
                        begin
                            remd_reg <= 65'(td - 66'(dd_reg));
                            numd_reg <= {numd_reg[63:0], 1'b1};
                        end
                        else
                        begin
                            remd_reg <= td[64:0];
                            numd_reg <= {numd_reg[63:0], 1'b0};
                        end
                        if (tb >= 66'(dd_reg))
                        begin
                            remb_reg <= 65'(tb - 66'(dd_reg));
                            numb_reg <= {numb_reg[63:0], 1'b1};
                        end
                        else
                        begin
                            remb_reg <= tb[64:0];
                            numb_reg <= {numb_reg[63:0], 1'b0};
                        end
                    end
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 7'd1)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    od_reg <= numd_reg[31:0];
                    ob_reg <= numb_reg[31:0];
                    ost_reg <= ST_INTERP;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import tli_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] energy;
    logic [31:0] delta_value;
    logic [31:0] beta_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] delta_result;
    logic [31:0] beta_result;
    logic [2:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    typedef struct packed {
        logic [31:0] dres;
        logic [31:0] bres;
        logic [2:0]  st;
    } answer_t;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] e;
        logic [31:0] dv;
        logic [31:0] bv;
        logic        has_fixed;
        answer_t     fixed;
    } row_t;

    // predictor copy of the table
    logic [31:0] pk [TableDepth];
    logic [31:0] pd [TableDepth];
    logic [31:0] pb [TableDepth];
    int          pcount;
    logic        pvac;

    answer_t     pending_answers[$];
    int          errors;
    int          queries_seen;
    int          words_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;
    int          hold_cycles;

    table_linear_interpolator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .energy(energy),
        .delta_value(delta_value), .beta_value(beta_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .delta_result(delta_result), .beta_result(beta_result), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #40000000;
        $display("testbench: FAIL");
        $finish;
    end

    // rounded linear blend between two table values
    function automatic logic [31:0] blend_values(logic [31:0] v0, logic [31:0] v1,
                                                 logic [31:0] n, logic [31:0] d);
        logic [63:0] acc;
        begin
            acc = 64'(v1) * 64'(n) + 64'(v0) * 64'(d - n) + 64'(d >> 1);
            return 32'(acc / 64'(d));
        end
    endfunction

    // apply one word to the predictor; returns 1 when a result is expected
    function automatic bit predict_word(logic [1:0] act, logic [31:0] e, logic [31:0] dv,
                                        logic [31:0] bv, output answer_t a);
        int i;
        logic [31:0] k0;
        begin
            a = '0;
            if (act == ACT_CLEAR)
            begin
                pcount = 0;
                return 0;
            end
            if (act == ACT_APPEND)
            begin
                if (pcount < TableDepth)
                begin
                    pk[pcount] = e;
                    pd[pcount] = dv;
                    pb[pcount] = bv;
                    pcount++;
                end
                return 0;
            end
            if (act != ACT_QUERY)
                return 0;
            if (pvac)
                a.st = ST_VACUUM;
            else if (pcount == 0)
                a.st = ST_EMPTY;
            else
            begin
                for (i = 0; i < pcount; i++)
                    if (e < pk[i])
                        break;
                if (i == pcount)
                begin
                    a.dres = pd[pcount-1];
                    a.bres = pb[pcount-1];
                    a.st = ST_HIGH;
                end
                else if (i == 0)
                begin
                    a.dres = pd[0];
                    a.bres = pb[0];
                    a.st = ST_LOW;
                end
                else
                begin
                    k0 = pk[i-1];
                    a.dres = blend_values(pd[i-1], pd[i], e - k0, pk[i] - k0);
                    a.bres = blend_values(pb[i-1], pb[i], e - k0, pk[i] - k0);
                    a.st = ST_INTERP;
                end
            end
            return 1;
        end
    endfunction

    // receiver: random stall, plus a long hold when requested
    always @(negedge clk)
    begin
        if (recv_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (recv_hold)
        begin
            hold_cycles++;
            if (hold_cycles >= 3000)
                recv_hold <= 1'b0;
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            queries_seen++;
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word delta=%h beta=%h status=%0d",
                         $time, delta_result, beta_result, status);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (delta_result !== want.dres)
                begin
                    errors++;
                    $display("%0t: delta expected %h actual %h", $time, want.dres, delta_result);
                end
                if (beta_result !== want.bres)
                begin
                    errors++;
                    $display("%0t: beta expected %h actual %h", $time, want.bres, beta_result);
                end
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
            end
        end
    end

    // drive one word from a falling edge after random idling; returns at the accepting edge
    task automatic send_word(logic [1:0] act, logic [31:0] e, logic [31:0] dv,
                             logic [31:0] bv, bit check_fixed, answer_t fixed);
        answer_t a;
        bit has;
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            action <= act;
            energy <= e;
            delta_value <= dv;
            beta_value <= bv;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            has = predict_word(act, e, dv, bv, a);
            if (has)
            begin
                if (check_fixed && a !== fixed)
                begin
                    errors++;
                    $display("%0t: directed row expected %h predicted %h", $time, fixed, a);
                end
                if (check_fixed)
                    a = fixed;
                pending_answers = {pending_answers, a};
            end
            words_sent++;
        end
    endtask

    task automatic drain;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_answers.size() != 0)
                @(negedge clk);
            repeat (400)
                @(negedge clk);
        end
    endtask

    task automatic write_vacuum(logic v);
        begin
            cfg_valid <= 1'b1;
            cfg_data <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            pvac = v;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // clear, then append an ascending table of the given length
    task automatic build_table(int len, bit wide);
        logic [31:0] k;
        int j;
        answer_t z;
        begin
            z = '0;
            send_word(ACT_CLEAR, $urandom, $urandom, $urandom, 0, z);
            k = $urandom_range(2000);
            for (j = 0; j < len; j++)
            begin
                send_word(ACT_APPEND, k, $urandom, $urandom, 0, z);
                k = k + (wide ? $urandom_range(32'h00ffffff, 1) : $urandom_range(3000, 1));
            end
        end
    endtask

    task automatic random_phase(int count);
        int j;
        int r;
        answer_t z;
        logic [31:0] e;
        begin
            z = '0;
            for (j = 0; j < count; j++)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    build_table($urandom_range(6, 1), $urandom_range(1) != 0);
                else if (r < 8)
                    send_word(ACT_APPEND, $urandom, $urandom, $urandom, 0, z);
                else if (r < 10)
                    send_word(ACT_NONE, $urandom, $urandom, $urandom, 0, z);
                else if (r < 11)
                    send_word(ACT_CLEAR, $urandom, $urandom, $urandom, 0, z);
                else
                begin
                    if (pcount > 0 && $urandom_range(3) != 0)
                        e = pk[$urandom_range(pcount - 1)] + $urandom_range(4000) - 1000;
                    else
                        e = $urandom;
                    send_word(ACT_QUERY, e, $urandom, $urandom, 0, z);
                end
            end
        end
    endtask

    row_t rows[$];

    function automatic row_t mk(logic [1:0] act, logic [31:0] e, logic [31:0] dv,
                                logic [31:0] bv, bit hf, logic [31:0] rd, logic [31:0] rb,
                                logic [2:0] rs);
        row_t r;
        begin
            r.act = act; r.e = e; r.dv = dv; r.bv = bv; r.has_fixed = hf;
            r.fixed.dres = rd; r.fixed.bres = rb; r.fixed.st = rs;
            return r;
        end
    endfunction

    // append one row to the directed table
    task automatic add_row(row_t r);
        begin
            rows = {rows, r};
        end
    endtask

    initial
    begin
        int j;
        answer_t z;
        z = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_CLEAR;
        energy = '0;
        delta_value = '0;
        beta_value = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        out_stall = 1'b0;
        recv_hold = 1'b0;
        hold_cycles = 0;
        errors = 0;
        queries_seen = 0;
        words_sent = 0;
        pcount = 0;
        pvac = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows: empty, extremes, clamps, interpolation, unused action
        add_row(mk(ACT_QUERY, 32'h0, 0, 0, 1, 0, 0, ST_EMPTY));
        add_row(mk(ACT_QUERY, 32'hffffffff, 0, 0, 1, 0, 0, ST_EMPTY));
        add_row(mk(ACT_APPEND, 32'h00010000, 32'h0, 32'hffffffff, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h00010000, 0, 0, 1, 32'h0, 32'hffffffff, ST_HIGH));
        add_row(mk(ACT_QUERY, 32'h0, 0, 0, 1, 32'h0, 32'hffffffff, ST_LOW));
        add_row(mk(ACT_APPEND, 32'h00020000, 32'hffffffff, 32'h0, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h00018000, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h0001ffff, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'hffffffff, 0, 0, 1, 32'hffffffff, 32'h0, ST_HIGH));
        add_row(mk(ACT_APPEND, 32'h00000000, 32'h12345678, 32'h9abcdef0, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h00010001, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h00000000, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h00005555, 0, 0, 1, 0, 0, ST_EMPTY));
        add_row(mk(ACT_APPEND, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0));
        add_row(mk(ACT_APPEND, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_QUERY, 32'hfffffffe, 0, 0, 0, 0, 0, 0));
        for (j = 0; j < rows.size(); j++)
            send_word(rows[j].act, rows[j].e, rows[j].dv, rows[j].bv,
                      rows[j].has_fixed, rows[j].fixed);
        drain();

        // vacuum mode, including on an empty table
        write_vacuum(1'b1);
        send_word(ACT_QUERY, 32'h00018000, 0, 0, 1, answer_t'({64'h0, ST_VACUUM}));
        send_word(ACT_CLEAR, 0, 0, 0, 0, z);
        send_word(ACT_QUERY, 32'h0, 0, 0, 1, answer_t'({64'h0, ST_VACUUM}));
        drain();
        write_vacuum(1'b0);

        // full table with a dropped append, mid scan queries
        build_table(TableDepth, 1'b0);
        send_word(ACT_APPEND, 32'hffffffff, 32'h1, 32'h1, 0, z);
        for (j = 0; j < 4; j++)
            send_word(ACT_QUERY, pk[$urandom_range(TableDepth - 1)] + 7, 0, 0, 0, z);
        send_word(ACT_QUERY, 32'hffffffff, 0, 0, 0, z);
        drain();

        // receiver idles more than sender
        send_idle_pct = 27;
        recv_idle_pct = 59;
        random_phase(300);
        drain();

        // long receiver hold while items keep coming
        recv_hold = 1'b1;
        hold_cycles = 0;
        send_idle_pct = 0;
        build_table(3, 1'b0);
        for (j = 0; j < 8; j++)
            send_word(ACT_QUERY, pk[0] + $urandom_range(6000), 0, 0, 0, z);
        drain();

        // sender idles more than receiver, vacuum briefly
        send_idle_pct = 59;
        recv_idle_pct = 27;
        write_vacuum(1'b1);
        random_phase(30);
        drain();
        write_vacuum(1'b0);
        random_phase(200);
        drain();

        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);
        drain();

        $display("sent %0d words, checked %0d query results", words_sent, queries_seen);
        $display("covered empty, vacuum, clamps, full table, interpolation and stalls");
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
